/* sv/ecpsm_pkg.sv */
// shared constants, state encoding and register indexes for the ec point core
// no dependencies
`default_nettype none

package ecpsm_pkg;

   // widths of the fixed interface fields
   localparam int DATA_WIDTH      = 64;
   localparam int SCALAR_WIDTH    = 64;
   localparam int FIELD_WIDTH_DEF = 64;
   localparam int REQ_DATA_WIDTH  = 320;
   localparam int REQ_USER_WIDTH  = 4;
   localparam int RSP_DATA_WIDTH  = 128;
   localparam int CSR_ADDR_WIDTH  = 4;

   // register reset values before masking to the field width
   localparam logic [DATA_WIDTH-1:0] PRIME_RESET   = 64'hFFFF_FFFF_FFFF_FFC5;
   localparam logic [DATA_WIDTH-1:0] CURVE_A_RESET = 64'h0;

   // register index, taken from address bit 3
   localparam logic REG_PRIME   = 1'b0;
   localparam logic REG_CURVE_A = 1'b1;

   // operation codes
   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_DOUBLE = 2'd1,
      FUNC_SMUL   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // reduction order of the input operands
   typedef enum logic [2:0] {
      RED_CA  = 3'd0,
      RED_AX  = 3'd1,
      RED_AY  = 3'd2,
      RED_BX  = 3'd3,
      RED_BY  = 3'd4
   } red_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_RED,
      ST_DISPATCH,
      ST_MUL_NORM,
      ST_MUL_STEP,
      ST_MUL_FIN,
      ST_DBL_CHK,
      ST_DBL_POST,
      ST_DBL_M1,
      ST_DBL_A1,
      ST_DBL_A2,
      ST_DBL_A3,
      ST_DBL_M2,
      ST_DBL_M3,
      ST_DBL_A4,
      ST_DBL_S1,
      ST_DBL_S2,
      ST_DBL_M4,
      ST_DBL_S3,
      ST_ADD_CHK,
      ST_ADD_POST,
      ST_ADD_S1,
      ST_ADD_M1,
      ST_ADD_M2,
      ST_ADD_S2,
      ST_ADD_S3,
      ST_ADD_S4,
      ST_ADD_M3,
      ST_ADD_S5,
      ST_INV_TEST,
      ST_INV_DIV,
      ST_INV_QRED,
      ST_INV_MUL,
      ST_INV_UPD,
      ST_PT_DONE,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

/* sv/ecpsm_mul.sv */
// bit-serial modular multiplier, msb first double-and-add, one modular add per cycle
// depends on ecpsm_pkg
`default_nettype none

module ecpsm_mul #(
   parameter int W = ecpsm_pkg::FIELD_WIDTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] op_a,
   input  wire logic [W-1:0] op_b,
   input  wire logic [W-1:0] modulus,
   output logic              done,
   output logic [W-1:0]      product
);

   localparam int CW = $clog2(W + 1);

   logic         busy_ff, busy_in;
   logic         ph_ff, ph_in;
   logic         done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0] r_ff, r_in;
   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] p_ff, p_in;

   function automatic logic [W-1:0] fadd(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[W-1:0];
   endfunction

   always_comb begin
      busy_in = busy_ff;
      ph_in   = ph_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      if (start) begin
         busy_in = 1'b1;
         ph_in   = 1'b0;
         cnt_in  = CW'(W);
         r_in    = '0;
         a_in    = op_a;
         b_in    = op_b;
         p_in    = modulus;
      end else if (busy_ff) begin
         if (!ph_ff) begin
            // doubling half of the step
            r_in  = fadd(r_ff, r_ff, p_ff);
            ph_in = 1'b1;
         end else begin
            if (b_ff[W-1]) begin
               r_in = fadd(r_ff, a_ff, p_ff);
            end
            b_in   = b_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            ph_in  = 1'b0;
            if (cnt_ff == CW'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ph_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ph_ff   <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("multiplier done without a running product");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> busy_ff || done_ff)
      else $error("multiplier stopped without done");
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> r_ff < p_ff)
      else $error("multiplier result not reduced");
`endif

endmodule

`default_nettype wire

/* sv/ecpsm_div.sv */
// bit-serial restoring divider giving quotient and remainder, one bit per cycle
// depends on ecpsm_pkg
`default_nettype none

module ecpsm_div #(
   parameter int W = ecpsm_pkg::FIELD_WIDTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient,
   output logic [W-1:0]      remainder
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  nq_ff, nq_in;
   logic [W-1:0]  d_ff, d_in;
   logic [W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      nq_in   = nq_ff;
      d_in    = d_ff;
      trial   = {rem_ff, nq_ff[W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         rem_in  = '0;
         nq_in   = dividend;
         d_in    = divisor;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract when it fits
         if (trial >= {1'b0, d_ff}) begin
            rem_in = W'(trial - {1'b0, d_ff});
            nq_in  = {nq_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            nq_in  = {nq_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      d_ff   <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = nq_ff;
   assign remainder = rem_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < d_ff)
      else $error("divider remainder not below divisor");
   a_keeps_going: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> busy_ff || done_ff)
      else $error("divider stopped without done");
`endif

endmodule

`default_nettype wire

/* sv/ec_point_scalar_multiply_core.sv */
// elliptic curve point add, double and scalar multiply over a configurable prime field
// depends on ecpsm_pkg, ecpsm_mul and ecpsm_div
`default_nettype none

// Affine short-Weierstrass point arithmetic over GF(p). One request beat carries an
// operation code and up to two points plus a signed scalar; one response beat returns
// the resulting point, with a flag for the point at infinity (its coordinates read 0).
// p and the curve coefficient a sit in two 64-bit registers at byte addresses 0 and 8,
// written by the user only while the core is idle; the core does not enforce this.
// The core works on one request at a time; a finished response waits in an output
// register while the next request is taken.
// Every field multiply goes through a bit-serial multiplier and every division through
// a bit-serial divider. Input reduction costs five divides. A field inverse is an
// extended Euclid loop of at most about 1.44*W steps, each one divide plus one
// multiply. A point double is one inverse plus four multiplies, a point add one
// inverse plus three, and an add of equal points runs a double after its failed
// inverse; a scalar multiply with an n-bit magnitude runs up to 2*(n-1) such point
// operations.
module ec_point_scalar_multiply_core #(
   parameter int FIELD_WIDTH = ecpsm_pkg::FIELD_WIDTH_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // request channel
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // first_x, first_y, second_x, second_y, scalar (64 bits each)
   input  wire logic [ecpsm_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   // func (2), first_is_zero (1), second_is_zero (1)
   input  wire logic [ecpsm_pkg::REQ_USER_WIDTH-1:0]     req_tuser,
   // response channel
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // result_x, result_y (64 bits each)
   output logic [ecpsm_pkg::RSP_DATA_WIDTH-1:0]          rsp_tdata,
   // result_is_zero
   output logic [0:0]                                    rsp_tuser,
   // register port
   input  wire logic                                     csr_psel,
   input  wire logic                                     csr_penable,
   input  wire logic                                     csr_pwrite,
   input  wire logic [ecpsm_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  wire logic [ecpsm_pkg::DATA_WIDTH-1:0]         csr_pwdata,
   output logic [ecpsm_pkg::DATA_WIDTH-1:0]              csr_prdata,
   output logic                                          csr_pready
);

   localparam int W  = FIELD_WIDTH;
   localparam int DW = ecpsm_pkg::DATA_WIDTH;
   localparam int SW = ecpsm_pkg::SCALAR_WIDTH;
   localparam int NW = $clog2(SW + 1);

   // configuration
   logic [W-1:0] p_ff, p_in;
   logic [W-1:0] ca_ff, ca_in;
   logic         csr_wr;

   // sequencer state
   ecpsm_pkg::state_type state_ff, state_in;
   ecpsm_pkg::func_type  func_ff, func_in;
   ecpsm_pkg::red_type   red_ff, red_in;
   logic         issued_ff, issued_in;
   logic         mul_mode_ff, mul_mode_in;
   logic         add_pend_ff, add_pend_in;
   logic         inv_add_ff, inv_add_in;
   logic         ok_ff, ok_in;
   logic         neg_ff, neg_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] n_ff, n_in;

   // points and working values
   logic [W-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic         acc_inf_ff, acc_inf_in;
   logic [W-1:0] opd_x_ff, opd_x_in, opd_y_ff, opd_y_in;
   logic         opd_inf_ff, opd_inf_in;
   logic [W-1:0] cw_ff, cw_in;
   logic [W-1:0] r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in, q_ff, q_in;
   logic [W-1:0] s_ff, s_in, t_ff, t_in, u_ff, u_in, rx_ff, rx_in;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic         rsp_z_ff, rsp_z_in;

   // serial units
   logic         mul_start, mul_done;
   logic [W-1:0] mul_a, mul_b, mul_res;
   logic         div_start, div_done;
   logic [W-1:0] div_n, div_d, div_q, div_r;

   logic [SW-1:0] k_raw;

   function automatic logic [W-1:0] fadd(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] fsub(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
      return (x >= y) ? (x - y) : (x - y + m);
   endfunction

   ecpsm_mul #(.W(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (p_ff),
      .done    (mul_done),
      .product (mul_res)
   );

   ecpsm_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      p_in  = p_ff;
      ca_in = ca_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3])
            ecpsm_pkg::REG_PRIME:   p_in  = csr_pwdata[W-1:0];
            ecpsm_pkg::REG_CURVE_A: ca_in = csr_pwdata[W-1:0];
            default:                p_in  = p_ff;
         endcase
      end
   end

   assign csr_prdata = (csr_paddr[3] == ecpsm_pkg::REG_CURVE_A) ? DW'(ca_ff) : DW'(p_ff);

   // operand selection for the serial units
   always_comb begin
      mul_a = s_ff;
      mul_b = s_ff;
      div_n = r0_ff;
      div_d = r1_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ecpsm_pkg::ST_INV_MUL: begin mul_a = q_ff;     mul_b = t1_ff;    mul_start = 1'b1; end
         ecpsm_pkg::ST_DBL_M1:  begin mul_a = acc_x_ff; mul_b = acc_x_ff; mul_start = 1'b1; end
         ecpsm_pkg::ST_DBL_M2:  begin mul_a = s_ff;     mul_b = t0_ff;    mul_start = 1'b1; end
         ecpsm_pkg::ST_DBL_M3:  begin mul_a = s_ff;     mul_b = s_ff;     mul_start = 1'b1; end
         ecpsm_pkg::ST_DBL_M4:  begin mul_a = s_ff;     mul_b = u_ff;     mul_start = 1'b1; end
         ecpsm_pkg::ST_ADD_M1:  begin mul_a = u_ff;     mul_b = t0_ff;    mul_start = 1'b1; end
         ecpsm_pkg::ST_ADD_M2:  begin mul_a = s_ff;     mul_b = s_ff;     mul_start = 1'b1; end
         ecpsm_pkg::ST_ADD_M3:  begin mul_a = s_ff;     mul_b = u_ff;     mul_start = 1'b1; end
         ecpsm_pkg::ST_INV_DIV: begin div_start = 1'b1; end
         ecpsm_pkg::ST_RED: begin
            div_d     = p_ff;
            div_start = 1'b1;
            unique case (red_ff)
               ecpsm_pkg::RED_CA: div_n = cw_ff;
               ecpsm_pkg::RED_AX: div_n = acc_x_ff;
               ecpsm_pkg::RED_AY: div_n = acc_y_ff;
               ecpsm_pkg::RED_BX: div_n = opd_x_ff;
               ecpsm_pkg::RED_BY: div_n = opd_y_ff;
               default:           div_n = cw_ff;
            endcase
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
      // a unit is started once, on the first cycle of its state
      mul_start = mul_start & ~issued_ff;
      div_start = div_start & ~issued_ff;
   end

   assign k_raw = req_tdata[5*DW-1:4*DW];

   // sequencer
   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      red_in      = red_ff;
      issued_in   = issued_ff;
      mul_mode_in = mul_mode_ff;
      add_pend_in = add_pend_ff;
      inv_add_in  = inv_add_ff;
      ok_in       = ok_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      acc_x_in    = acc_x_ff;
      acc_y_in    = acc_y_ff;
      acc_inf_in  = acc_inf_ff;
      opd_x_in    = opd_x_ff;
      opd_y_in    = opd_y_ff;
      opd_inf_in  = opd_inf_ff;
      cw_in       = cw_ff;
      r0_in       = r0_ff;
      r1_in       = r1_ff;
      t0_in       = t0_ff;
      t1_in       = t1_ff;
      q_in        = q_ff;
      s_in        = s_ff;
      t_in        = t_ff;
      u_in        = u_ff;
      rx_in       = rx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_z_in    = rsp_z_ff;
      req_tready  = 1'b0;

      if (mul_start || div_start) begin
         issued_in = 1'b1;
      end

      unique case (state_ff)
         ecpsm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               acc_x_in   = req_tdata[W-1:0];
               acc_y_in   = req_tdata[DW+W-1:DW];
               opd_x_in   = req_tdata[2*DW+W-1:2*DW];
               opd_y_in   = req_tdata[3*DW+W-1:3*DW];
               acc_inf_in = req_tuser[2];
               opd_inf_in = req_tuser[3];
               func_in    = ecpsm_pkg::func_type'(req_tuser[1:0]);
               cw_in      = ca_ff;
               neg_in     = k_raw[SW-1];
               n_in       = k_raw[SW-1] ? (~k_raw + SW'(1)) : k_raw;
               red_in     = ecpsm_pkg::RED_CA;
               mul_mode_in = 1'b0;
               add_pend_in = 1'b0;
               if (p_ff < W'(2)) begin
                  // degenerate modulus
                  acc_inf_in = 1'b1;
                  state_in   = ecpsm_pkg::ST_OUT;
               end else begin
                  state_in = ecpsm_pkg::ST_RED;
               end
            end
         end

         ecpsm_pkg::ST_RED: begin
            if (div_done) begin
               issued_in = 1'b0;
               unique case (red_ff)
                  ecpsm_pkg::RED_CA: begin cw_in    = div_r; red_in = ecpsm_pkg::RED_AX; end
                  ecpsm_pkg::RED_AX: begin acc_x_in = div_r; red_in = ecpsm_pkg::RED_AY; end
                  ecpsm_pkg::RED_AY: begin acc_y_in = div_r; red_in = ecpsm_pkg::RED_BX; end
                  ecpsm_pkg::RED_BX: begin opd_x_in = div_r; red_in = ecpsm_pkg::RED_BY; end
                  ecpsm_pkg::RED_BY: begin opd_y_in = div_r; state_in = ecpsm_pkg::ST_DISPATCH; end
                  default:           state_in = ecpsm_pkg::ST_DISPATCH;
               endcase
            end
         end

         ecpsm_pkg::ST_DISPATCH: begin
            unique case (func_ff)
               ecpsm_pkg::FUNC_ADD:    state_in = ecpsm_pkg::ST_ADD_CHK;
               ecpsm_pkg::FUNC_DOUBLE: state_in = ecpsm_pkg::ST_DBL_CHK;
               ecpsm_pkg::FUNC_SMUL: begin
                  // base point is kept as the add operand
                  mul_mode_in = 1'b1;
                  opd_x_in    = acc_x_ff;
                  opd_y_in    = acc_y_ff;
                  opd_inf_in  = acc_inf_ff;
                  cnt_in      = NW'(SW);
                  if (n_ff == '0 || acc_inf_ff) begin
                     acc_inf_in = 1'b1;
                     state_in   = ecpsm_pkg::ST_OUT;
                  end else begin
                     state_in = ecpsm_pkg::ST_MUL_NORM;
                  end
               end
               default: begin
                  acc_inf_in = 1'b1;
                  state_in   = ecpsm_pkg::ST_OUT;
               end
            endcase
         end

         // skip leading zeros and the top set bit of the magnitude
         ecpsm_pkg::ST_MUL_NORM: begin
            n_in   = n_ff << 1;
            cnt_in = cnt_ff - NW'(1);
            if (n_ff[SW-1]) begin
               state_in = ecpsm_pkg::ST_MUL_STEP;
            end
         end

         ecpsm_pkg::ST_MUL_STEP: begin
            if (cnt_ff == '0) begin
               state_in = ecpsm_pkg::ST_MUL_FIN;
            end else begin
               add_pend_in = n_ff[SW-1];
               n_in        = n_ff << 1;
               cnt_in      = cnt_ff - NW'(1);
               state_in    = ecpsm_pkg::ST_DBL_CHK;
            end
         end

         ecpsm_pkg::ST_MUL_FIN: begin
            // negative scalar, y of zero stays zero
            if (neg_ff && !acc_inf_ff && acc_y_ff != '0) begin
               acc_y_in = p_ff - acc_y_ff;
            end
            state_in = ecpsm_pkg::ST_OUT;
         end

         // point double
         ecpsm_pkg::ST_DBL_CHK: begin
            if (acc_inf_ff || acc_y_ff == '0) begin
               acc_inf_in = 1'b1;
               state_in   = ecpsm_pkg::ST_PT_DONE;
            end else begin
               r0_in      = p_ff;
               r1_in      = fadd(acc_y_ff, acc_y_ff, p_ff);
               t0_in      = '0;
               t1_in      = W'(1);
               inv_add_in = 1'b0;
               state_in   = ecpsm_pkg::ST_INV_TEST;
            end
         end
         ecpsm_pkg::ST_DBL_POST: begin
            if (!ok_ff) begin
               acc_inf_in = 1'b1;
               state_in   = ecpsm_pkg::ST_PT_DONE;
            end else begin
               state_in = ecpsm_pkg::ST_DBL_M1;
            end
         end
         ecpsm_pkg::ST_DBL_M1: begin
            if (mul_done) begin
               issued_in = 1'b0;
               t_in      = mul_res;
               state_in  = ecpsm_pkg::ST_DBL_A1;
            end
         end
         ecpsm_pkg::ST_DBL_A1: begin
            s_in     = fadd(t_ff, t_ff, p_ff);
            state_in = ecpsm_pkg::ST_DBL_A2;
         end
         ecpsm_pkg::ST_DBL_A2: begin
            s_in     = fadd(s_ff, t_ff, p_ff);
            state_in = ecpsm_pkg::ST_DBL_A3;
         end
         ecpsm_pkg::ST_DBL_A3: begin
            s_in     = fadd(s_ff, cw_ff, p_ff);
            state_in = ecpsm_pkg::ST_DBL_M2;
         end
         ecpsm_pkg::ST_DBL_M2: begin
            if (mul_done) begin
               issued_in = 1'b0;
               s_in      = mul_res;
               state_in  = ecpsm_pkg::ST_DBL_M3;
            end
         end
         ecpsm_pkg::ST_DBL_M3: begin
            if (mul_done) begin
               issued_in = 1'b0;
               t_in      = mul_res;
               state_in  = ecpsm_pkg::ST_DBL_A4;
            end
         end
         ecpsm_pkg::ST_DBL_A4: begin
            u_in     = fadd(acc_x_ff, acc_x_ff, p_ff);
            state_in = ecpsm_pkg::ST_DBL_S1;
         end
         ecpsm_pkg::ST_DBL_S1: begin
            rx_in    = fsub(t_ff, u_ff, p_ff);
            state_in = ecpsm_pkg::ST_DBL_S2;
         end
         ecpsm_pkg::ST_DBL_S2: begin
            u_in     = fsub(acc_x_ff, rx_ff, p_ff);
            state_in = ecpsm_pkg::ST_DBL_M4;
         end
         ecpsm_pkg::ST_DBL_M4: begin
            if (mul_done) begin
               issued_in = 1'b0;
               t_in      = mul_res;
               state_in  = ecpsm_pkg::ST_DBL_S3;
            end
         end
         ecpsm_pkg::ST_DBL_S3: begin
            acc_y_in   = fsub(t_ff, acc_y_ff, p_ff);
            acc_x_in   = rx_ff;
            acc_inf_in = 1'b0;
            state_in   = ecpsm_pkg::ST_PT_DONE;
         end

         // point add, acc plus operand
         ecpsm_pkg::ST_ADD_CHK: begin
            if (acc_inf_ff) begin
               acc_x_in   = opd_x_ff;
               acc_y_in   = opd_y_ff;
               acc_inf_in = opd_inf_ff;
               state_in   = ecpsm_pkg::ST_PT_DONE;
            end else if (opd_inf_ff) begin
               state_in = ecpsm_pkg::ST_PT_DONE;
            end else begin
               r0_in      = p_ff;
               r1_in      = fsub(acc_x_ff, opd_x_ff, p_ff);
               t0_in      = '0;
               t1_in      = W'(1);
               inv_add_in = 1'b1;
               state_in   = ecpsm_pkg::ST_INV_TEST;
            end
         end
         ecpsm_pkg::ST_ADD_POST: begin
            if (!ok_ff) begin
               // same x: equal points double, opposite points cancel
               if (acc_y_ff == opd_y_ff) begin
                  state_in = ecpsm_pkg::ST_DBL_CHK;
               end else begin
                  acc_inf_in = 1'b1;
                  state_in   = ecpsm_pkg::ST_PT_DONE;
               end
            end else begin
               state_in = ecpsm_pkg::ST_ADD_S1;
            end
         end
         ecpsm_pkg::ST_ADD_S1: begin
            u_in     = fsub(acc_y_ff, opd_y_ff, p_ff);
            state_in = ecpsm_pkg::ST_ADD_M1;
         end
         ecpsm_pkg::ST_ADD_M1: begin
            if (mul_done) begin
               issued_in = 1'b0;
               s_in      = mul_res;
               state_in  = ecpsm_pkg::ST_ADD_M2;
            end
         end
         ecpsm_pkg::ST_ADD_M2: begin
            if (mul_done) begin
               issued_in = 1'b0;
               t_in      = mul_res;
               state_in  = ecpsm_pkg::ST_ADD_S2;
            end
         end
         ecpsm_pkg::ST_ADD_S2: begin
            t_in     = fsub(t_ff, acc_x_ff, p_ff);
            state_in = ecpsm_pkg::ST_ADD_S3;
         end
         ecpsm_pkg::ST_ADD_S3: begin
            rx_in    = fsub(t_ff, opd_x_ff, p_ff);
            state_in = ecpsm_pkg::ST_ADD_S4;
         end
         ecpsm_pkg::ST_ADD_S4: begin
            u_in     = fsub(opd_x_ff, rx_ff, p_ff);
            state_in = ecpsm_pkg::ST_ADD_M3;
         end
         ecpsm_pkg::ST_ADD_M3: begin
            if (mul_done) begin
               issued_in = 1'b0;
               t_in      = mul_res;
               state_in  = ecpsm_pkg::ST_ADD_S5;
            end
         end
         ecpsm_pkg::ST_ADD_S5: begin
            acc_y_in   = fsub(t_ff, opd_y_ff, p_ff);
            acc_x_in   = rx_ff;
            acc_inf_in = 1'b0;
            state_in   = ecpsm_pkg::ST_PT_DONE;
         end

         // extended euclid inverse of r1 mod p, result in t0
         ecpsm_pkg::ST_INV_TEST: begin
            if (r1_ff == '0) begin
               ok_in    = (r0_ff == W'(1));
               state_in = inv_add_ff ? ecpsm_pkg::ST_ADD_POST : ecpsm_pkg::ST_DBL_POST;
            end else begin
               state_in = ecpsm_pkg::ST_INV_DIV;
            end
         end
         ecpsm_pkg::ST_INV_DIV: begin
            if (div_done) begin
               issued_in = 1'b0;
               q_in      = div_q;
               r0_in     = r1_ff;
               r1_in     = div_r;
               state_in  = ecpsm_pkg::ST_INV_QRED;
            end
         end
         ecpsm_pkg::ST_INV_QRED: begin
            if (q_ff >= p_ff) begin
               q_in = q_ff - p_ff;
            end
            state_in = ecpsm_pkg::ST_INV_MUL;
         end
         ecpsm_pkg::ST_INV_MUL: begin
            if (mul_done) begin
               issued_in = 1'b0;
               t_in      = mul_res;
               state_in  = ecpsm_pkg::ST_INV_UPD;
            end
         end
         ecpsm_pkg::ST_INV_UPD: begin
            t0_in    = t1_ff;
            t1_in    = fsub(t0_ff, t_ff, p_ff);
            state_in = ecpsm_pkg::ST_INV_TEST;
         end

         ecpsm_pkg::ST_PT_DONE: begin
            if (!mul_mode_ff) begin
               state_in = ecpsm_pkg::ST_OUT;
            end else if (add_pend_ff) begin
               add_pend_in = 1'b0;
               state_in    = ecpsm_pkg::ST_ADD_CHK;
            end else begin
               state_in = ecpsm_pkg::ST_MUL_STEP;
            end
         end

         ecpsm_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = acc_inf_ff ? '0 : acc_x_ff;
               rsp_y_in     = acc_inf_ff ? '0 : acc_y_ff;
               rsp_z_in     = acc_inf_ff;
               state_in     = ecpsm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ecpsm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ecpsm_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         p_ff         <= ecpsm_pkg::PRIME_RESET[W-1:0];
         ca_ff        <= ecpsm_pkg::CURVE_A_RESET[W-1:0];
         mul_mode_ff  <= 1'b0;
         add_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         p_ff         <= p_in;
         ca_ff        <= ca_in;
         mul_mode_ff  <= mul_mode_in;
         add_pend_ff  <= add_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      red_ff     <= red_in;
      inv_add_ff <= inv_add_in;
      ok_ff      <= ok_in;
      neg_ff     <= neg_in;
      cnt_ff     <= cnt_in;
      n_ff       <= n_in;
      acc_x_ff   <= acc_x_in;
      acc_y_ff   <= acc_y_in;
      acc_inf_ff <= acc_inf_in;
      opd_x_ff   <= opd_x_in;
      opd_y_ff   <= opd_y_in;
      opd_inf_ff <= opd_inf_in;
      cw_ff      <= cw_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      t0_ff      <= t0_in;
      t1_ff      <= t1_in;
      q_ff       <= q_in;
      s_ff       <= s_in;
      t_ff       <= t_in;
      u_ff       <= u_in;
      rx_ff      <= rx_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {DW'(rsp_y_ff), DW'(rsp_x_ff)};
   assign rsp_tuser  = rsp_z_ff;

`ifndef SYNTHESIS
   a_inf_zero_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_z_ff |-> rsp_x_ff == '0 && rsp_y_ff == '0)
      else $error("infinity response with nonzero coordinates");
   a_mul_done_issued: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> issued_ff)
      else $error("multiplier done with nothing issued");
   a_div_done_issued: assert property (@(posedge clock) disable iff (reset)
      div_done |-> issued_ff)
      else $error("divider done with nothing issued");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ecpsm_pkg::ST_IDLE)
      else $error("request beat taken but sequencer stayed idle");
   a_resp_reduced: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && !rsp_z_ff |-> rsp_x_ff < p_ff && rsp_y_ff < p_ff)
      else $error("response coordinate not reduced");
`endif

endmodule

`default_nettype wire

/* dv/ec_point_checker.sv */
// predicts and checks response beats of the ec point core from observed request beats
// depends on ecpsm_pkg for the operation codes, channel widths, reset values and register index
module ec_point_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   input  wire logic                                 req_tready,
   input  wire logic [ecpsm_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  wire logic [ecpsm_pkg::REQ_USER_WIDTH-1:0] req_tuser,
   input  wire logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic [ecpsm_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  wire logic [0:0]                           rsp_tuser,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ecpsm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [ecpsm_pkg::DATA_WIDTH-1:0]     csr_pwdata,
   input  wire logic                                 csr_pready,
   output int                                        fail_count,
   output int                                        points_owed
);

   typedef struct packed {
      logic [63:0] x;
      logic [63:0] y;
      logic        inf;
   } ec_point_type;

   logic [63:0]  modulus;
   logic [63:0]  coef_a;
   ec_point_type owed_points[$];

   function automatic logic [63:0] f_add(logic [63:0] a, logic [63:0] b, logic [63:0] p);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, p}) s = s - {1'b0, p};
      return s[63:0];
   endfunction

   function automatic logic [63:0] f_sub(logic [63:0] a, logic [63:0] b, logic [63:0] p);
      return (a >= b) ? a - b : a - b + p;
   endfunction

   function automatic logic [63:0] f_mul(logic [63:0] a, logic [63:0] b, logic [63:0] p);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, p});
   endfunction

   // extended euclid, fails when gcd is not 1
   function automatic logic f_inv(logic [63:0] v, logic [63:0] p, output logic [63:0] inv);
      logic [63:0] r0, r1, t0, t1, q, rn, tn;
      r0 = p; r1 = v; t0 = 0; t1 = 1; inv = 0;
      while (r1 != 0) begin
         q = r0 / r1;
         rn = r0 - q * r1;
         tn = f_sub(t0, f_mul(q % p, t1, p), p);
         r0 = r1; r1 = rn;
         t0 = t1; t1 = tn;
      end
      if (r0 != 1) return 1'b0;
      inv = t0;
      return 1'b1;
   endfunction

   function automatic ec_point_type infinity();
      return '{x: 64'd0, y: 64'd0, inf: 1'b1};
   endfunction

   function automatic ec_point_type pt_double(ec_point_type a, logic [63:0] p,
                                              logic [63:0] ca);
      ec_point_type r;
      logic [63:0] num, inv, s;
      if (a.inf || a.y == 0) return infinity();
      if (!f_inv(f_add(a.y, a.y, p), p, inv)) return infinity();
      num = f_mul(a.x, a.x, p);
      num = f_add(f_add(num, num, p), num, p);
      num = f_add(num, ca, p);
      s = f_mul(num, inv, p);
      r.x = f_sub(f_mul(s, s, p), f_add(a.x, a.x, p), p);
      r.y = f_sub(f_mul(s, f_sub(a.x, r.x, p), p), a.y, p);
      r.inf = 1'b0;
      return r;
   endfunction

   function automatic ec_point_type pt_sum(ec_point_type a, ec_point_type b, logic [63:0] p,
                                           logic [63:0] ca);
      ec_point_type r;
      logic [63:0] inv, s;
      if (a.inf) return b.inf ? infinity() : b;
      if (b.inf) return a;
      // vertical line: same point doubles, mirrored points cancel
      if (!f_inv(f_sub(a.x, b.x, p), p, inv))
         return (a.y == b.y) ? pt_double(a, p, ca) : infinity();
      s = f_mul(f_sub(a.y, b.y, p), inv, p);
      r.x = f_sub(f_sub(f_mul(s, s, p), a.x, p), b.x, p);
      r.y = f_sub(f_mul(s, f_sub(b.x, r.x, p), p), b.y, p);
      r.inf = 1'b0;
      return r;
   endfunction

   function automatic ec_point_type pt_scale(ec_point_type a, logic [63:0] k, logic [63:0] p,
                                             logic [63:0] ca);
      ec_point_type acc;
      logic [63:0] mag;
      int top;
      mag = k[63] ? -k : k;
      if (mag == 0 || a.inf) return infinity();
      top = 63;
      while (!mag[top]) top--;
      acc = a;
      for (int i = top - 1; i >= 0; i--) begin
         acc = pt_double(acc, p, ca);
         if (mag[i]) acc = pt_sum(acc, a, p, ca);
      end
      if (acc.inf) return infinity();
      if (k[63] && acc.y != 0) acc.y = p - acc.y;
      return acc;
   endfunction

   function automatic ec_point_type predict_point(logic [319:0] d, logic [3:0] u,
                                                  logic [63:0] p, logic [63:0] a_reg);
      ec_point_type a, b, r;
      logic [63:0] ca;
      ecpsm_pkg::func_type op;
      if (p < 2) return infinity();
      op = ecpsm_pkg::func_type'(u[1:0]);
      ca = a_reg % p;
      a = '{x: d[63:0] % p, y: d[127:64] % p, inf: u[2]};
      b = '{x: d[191:128] % p, y: d[255:192] % p, inf: u[3]};
      case (op)
         ecpsm_pkg::FUNC_ADD:    r = pt_sum(a, b, p, ca);
         ecpsm_pkg::FUNC_DOUBLE: r = pt_double(a, p, ca);
         ecpsm_pkg::FUNC_SMUL:   r = pt_scale(a, d[319:256], p, ca);
         default:                r = infinity();
      endcase
      if (r.inf) r = infinity();
      return r;
   endfunction

   always @(posedge clock) begin
      ec_point_type want;
      int           errs;
      errs = 0;
      if (reset) begin
         modulus <= ecpsm_pkg::PRIME_RESET;
         coef_a <= ecpsm_pkg::CURVE_A_RESET;
         fail_count <= 0;
         points_owed <= 0;
         owed_points.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[3] == ecpsm_pkg::REG_PRIME) modulus <= csr_pwdata;
            else coef_a <= csr_pwdata;
         end
         if (req_tvalid && req_tready)
            owed_points.push_back(predict_point(req_tdata, req_tuser, modulus, coef_a));
         if (rsp_tvalid && rsp_tready) begin
            if (owed_points.size() == 0) begin
               $error("unexpected response beat");
               errs++;
            end else begin
               want = owed_points.pop_front();
               if (rsp_tdata[63:0] !== want.x) begin
                  $error("result_x expected %h got %h", want.x, rsp_tdata[63:0]);
                  errs++;
               end
               if (rsp_tdata[127:64] !== want.y) begin
                  $error("result_y expected %h got %h", want.y, rsp_tdata[127:64]);
                  errs++;
               end
               if (rsp_tuser[0] !== want.inf) begin
                  $error("result_is_zero expected %b got %b", want.inf, rsp_tuser[0]);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         points_owed <= owed_points.size();
      end
   end
endmodule

/* dv/tb_top.sv */
// stimulus and verdict for the ec point core: directed corner cases, then random beats
// depends on ecpsm_pkg, ec_point_scalar_multiply_core and ec_point_checker
module tb_top;

   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam logic [63:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   // first_x, first_y, second_x, second_y, scalar
   logic [319:0] req_tdata = '0;
   // func, first_is_zero, second_is_zero
   logic [3:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   // result_x, result_y
   logic [127:0] rsp_tdata;
   // result_is_zero
   logic [0:0]   rsp_tuser;
   logic         csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]   csr_paddr = '0;
   logic [63:0]  csr_pwdata = '0;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   int     fail_count, points_owed;
   int     send_idle_pct = 9, recv_idle_pct = 69;
   longint cycle_count = 0;
   logic [63:0] cur_p = BIG_PRIME;

   ec_point_scalar_multiply_core u_top (.*);

   ec_point_checker u_checker (.*);

   initial forever #5 clock = ~clock;

   // receiver stalls at the current rate
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // coordinate below p, sometimes zero or left unreduced
   function automatic logic [63:0] rand_coord();
      case ($urandom_range(15))
         0: return 64'd0;
         1, 2: return rand64();
         default: return rand64() % cur_p;
      endcase
   endfunction

   // one request beat; the sender may idle before it
   task automatic send(ecpsm_pkg::func_type op, logic [63:0] ax, logic [63:0] ay, logic az,
                       logic [63:0] bx, logic [63:0] by, logic bz, logic [63:0] k);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {k, by, bx, ay, ax};
      req_tuser <= {bz, az, op};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (points_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_idx, logic [63:0] val);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {reg_idx, 3'b000}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
      if (reg_idx == ecpsm_pkg::REG_PRIME) cur_p = val;
   endtask

   // random beat; small scalars unless p is small enough to keep long chains cheap
   task automatic random_beat();
      logic [63:0] ax, ay, bx, by, k;
      ecpsm_pkg::func_type op;
      ax = rand_coord(); ay = rand_coord();
      bx = rand_coord(); by = rand_coord();
      case ($urandom_range(7))
         0: begin bx = ax; by = ay; end                          // same point
         1: begin bx = ax; by = (ay % cur_p == 0) ? 0 : cur_p - ay % cur_p; end  // mirror
         default: ;
      endcase
      if (cur_p < 64'd65536 && $urandom_range(3) == 0) k = rand64();
      else begin
         k = 64'($urandom_range(31));
         if ($urandom_range(1)) k = -k;
      end
      if ($urandom_range(12) == 0) op = ecpsm_pkg::FUNC_NONE;
      else op = ecpsm_pkg::func_type'(2'($urandom_range(2)));
      send(op, ax, ay, $urandom_range(15) == 0, bx, by, $urandom_range(15) == 0, k);
   endtask

   task automatic random_run(int n);
      repeat (n) random_beat();
   endtask

   initial begin
      logic [63:0] gx, gy;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners under the reset modulus
      gx = rand64() % cur_p; gy = rand64() % cur_p;
      send(ecpsm_pkg::FUNC_ADD, gx, gy, 0, rand64() % cur_p, rand64() % cur_p, 0, 0);
      send(ecpsm_pkg::FUNC_ADD, gx, gy, 1, 5, 7, 0, 0);              // infinite first
      send(ecpsm_pkg::FUNC_ADD, gx, gy, 0, 5, 7, 1, 0);              // infinite second
      send(ecpsm_pkg::FUNC_ADD, gx, gy, 1, 5, 7, 1, 0);              // both infinite
      send(ecpsm_pkg::FUNC_ADD, gx, gy, 0, gx, cur_p - gy, 0, 0);    // p plus minus p
      send(ecpsm_pkg::FUNC_ADD, gx, gy, 0, gx, gy, 0, 0);            // equal points
      send(ecpsm_pkg::FUNC_DOUBLE, gx, 0, 0, 0, 0, 0, 0);            // y zero
      send(ecpsm_pkg::FUNC_DOUBLE, gx, gy, 0, 0, 0, 0, 0);
      send(ecpsm_pkg::FUNC_DOUBLE, '1, '1, 0, '1, '1, 1, '1);        // unreduced
      send(ecpsm_pkg::FUNC_NONE, gx, gy, 0, gx, gy, 0, 9);
      send(ecpsm_pkg::FUNC_SMUL, gx, gy, 0, 0, 0, 0, 0);             // zero scalar
      send(ecpsm_pkg::FUNC_SMUL, gx, gy, 1, 0, 0, 0, 5);             // infinite first
      send(ecpsm_pkg::FUNC_SMUL, gx, gy, 0, 0, 0, 0, 13);
      send(ecpsm_pkg::FUNC_SMUL, gx, gy, 0, 0, 0, 0, -64'sd3);       // negative
      drain();

      // small field for long scalars, a at the top of its range
      csr_write(ecpsm_pkg::REG_PRIME, 64'd97);
      csr_write(ecpsm_pkg::REG_CURVE_A, '1);
      send(ecpsm_pkg::FUNC_SMUL, 3, 6, 0, 0, 0, 0, 64'h8000_0000_0000_0000);  // most negative
      send(ecpsm_pkg::FUNC_SMUL, 3, 6, 0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
      send(ecpsm_pkg::FUNC_SMUL, 3, 6, 0, 0, 0, 0, '1);                       // minus one
      send(ecpsm_pkg::FUNC_SMUL, 10, 0, 0, 0, 0, 0, -64'sd2);         // y zero stays zero
      send(ecpsm_pkg::FUNC_ADD, '1, 0, 0, 64'h60, 0, 0, 0);
      random_run(30);
      drain();

      // modulus 3, then the largest (composite) with a = 0
      csr_write(ecpsm_pkg::REG_PRIME, 64'd3);
      random_run(4);
      drain();
      send_idle_pct = 69; recv_idle_pct = 9;
      csr_write(ecpsm_pkg::REG_PRIME, '1);
      csr_write(ecpsm_pkg::REG_CURVE_A, 64'd0);
      random_run(28);
      drain();

      // mid prime, no idling
      send_idle_pct = 0; recv_idle_pct = 0;
      csr_write(ecpsm_pkg::REG_PRIME, 64'd1000003);
      csr_write(ecpsm_pkg::REG_CURVE_A, rand64());
      random_run(30);
      drain();
      repeat (50) @(posedge clock);

      if (fail_count == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end
endmodule
